// ===== sv/kqs_pkg.sv =====
// Shared definitions for the k_queues_shared_store block.
// Holds sizes, pointer encodings, status and action codes, and the control state type.
// Has no dependencies; the link table and the top level refer to it by scoped names.
`default_nettype none

package kqs_pkg;

    localparam int SLOTS       = 16;
    localparam int QUEUE_COUNT = 4;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int QNUM_W = 2;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    localparam logic [PTR_W-1:0] NIL_SLOT = PTR_W'(SLOTS);

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [PTR_W-1:0]  data;
    } t_link_wr;

    function automatic logic slot_ok(input logic [PTR_W-1:0] ptr);
        return ptr < NIL_SLOT;
    endfunction

    // Link value that an entry holds after reset: the next slot, or null for the last one.
    function automatic logic [PTR_W-1:0] link_default(input logic [SLOT_W-1:0] addr);
        if (addr == SLOT_W'(SLOTS - 1)) begin
            return NIL_SLOT;
        end
        return PTR_W'(addr) + PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== sv/kqs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are set by parameters; it has no other dependencies.
`default_nettype none

module kqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/kqs_link.sv =====
// Link table: a RAM of next pointers plus one valid bit per entry.
// An entry never written reads as its reset chain value. Depends on kqs_pkg and kqs_ram.
`default_nettype none

module kqs_link (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_rd_en,
    input  wire logic [kqs_pkg::SLOT_W-1:0]   i_rd_addr,
    input  wire kqs_pkg::t_link_wr            i_wr,
    output      logic [kqs_pkg::PTR_W-1:0]    o_rd_next
);

    logic [kqs_pkg::SLOTS-1:0]  r_vld;
    logic                       r_rd_vld;
    logic [kqs_pkg::SLOT_W-1:0] r_rd_addr;
    logic [kqs_pkg::PTR_W-1:0]  ram_q;

    kqs_ram #(
        .WIDTH (kqs_pkg::PTR_W),
        .DEPTH (kqs_pkg::SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_vld  <= r_vld[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    assign o_rd_next = r_rd_vld ? ram_q : kqs_pkg::link_default(r_rd_addr);

endmodule

`default_nettype wire

// ===== sv/k_queues_shared_store.sv =====
// Top level of k_queues_shared_store: queue pointers, free list and operation control.
// Depends on kqs_pkg, kqs_link and kqs_ram.
`default_nettype none

// Four FIFO queues share a store of sixteen 32-bit slots. A command is taken when start is
// high and busy is low; the command first reads the link table and the value store, then
// writes back the updated pointers and the value. The result appears on o_status and
// o_read_value with o_done high for exactly one cycle, in the cycle after the write-back,
// and must be captured then since the block cannot be held off. An enqueue with no free
// slot reports full and a dequeue from an empty queue reports empty; neither changes any
// state. There is no initialization pass after reset.
module k_queues_shared_store (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic                              i_action,
    input  wire logic [kqs_pkg::QNUM_W-1:0]        i_queue_number,
    input  wire logic signed [kqs_pkg::DATA_W-1:0] i_data_value,
    output      logic                              o_done,
    output      logic [kqs_pkg::STAT_W-1:0]        o_status,
    output      logic signed [kqs_pkg::DATA_W-1:0] o_read_value
);

    kqs_pkg::t_state r_state, n_state;

    logic                        r_action;
    logic [kqs_pkg::QNUM_W-1:0]  r_qnum;
    logic [kqs_pkg::DATA_W-1:0]  r_data;
    logic [kqs_pkg::PTR_W-1:0]   r_head [kqs_pkg::QUEUE_COUNT];
    logic [kqs_pkg::SLOT_W-1:0]  r_tail [kqs_pkg::QUEUE_COUNT];
    logic [kqs_pkg::PTR_W-1:0]   r_free_head, n_free_head;
    logic [kqs_pkg::PTR_W-1:0]   n_head;
    logic [kqs_pkg::SLOT_W-1:0]  n_tail;
    logic                        head_we, tail_we;
    logic                        r_done, n_done;
    kqs_pkg::t_status            r_status, n_status;
    logic [kqs_pkg::DATA_W-1:0]  r_read_value, n_read_value;

    logic                        accept;
    logic [kqs_pkg::PTR_W-1:0]   in_head;
    logic [kqs_pkg::SLOT_W-1:0]  link_rd_addr;
    logic [kqs_pkg::PTR_W-1:0]   link_next;
    kqs_pkg::t_link_wr           link_wr;
    logic                        val_we;
    logic [kqs_pkg::DATA_W-1:0]  val_q;
    logic [kqs_pkg::PTR_W-1:0]   head_cur;
    logic [kqs_pkg::SLOT_W-1:0]  tail_cur;

    assign busy    = (r_state != kqs_pkg::S_IDLE);
    assign accept  = start && !busy;
    assign in_head = r_head[i_queue_number];
    assign link_rd_addr = (i_action == kqs_pkg::ACT_ENQ) ?
                          r_free_head[kqs_pkg::SLOT_W-1:0] : in_head[kqs_pkg::SLOT_W-1:0];

    kqs_link u_link (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (link_rd_addr),
        .i_wr      (link_wr),
        .o_rd_next (link_next)
    );

    kqs_ram #(
        .WIDTH (kqs_pkg::DATA_W),
        .DEPTH (kqs_pkg::SLOTS)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_free_head[kqs_pkg::SLOT_W-1:0]),
        .i_wdata (r_data),
        .i_re    (accept),
        .i_raddr (in_head[kqs_pkg::SLOT_W-1:0]),
        .o_rdata (val_q)
    );

    assign head_cur = r_head[r_qnum];
    assign tail_cur = r_tail[r_qnum];

    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_head       = head_cur;
        n_tail       = tail_cur;
        head_we      = 1'b0;
        tail_we      = 1'b0;
        val_we       = 1'b0;
        link_wr      = '0;
        n_done       = 1'b0;
        n_status     = kqs_pkg::ST_OK;
        n_read_value = '0;
        unique case (r_state)
            kqs_pkg::S_IDLE: begin
                if (start) begin
                    n_state = kqs_pkg::S_EXEC;
                end
            end
            kqs_pkg::S_EXEC: begin
                n_state = kqs_pkg::S_IDLE;
                n_done  = 1'b1;
                if (r_action == kqs_pkg::ACT_ENQ) begin
                    if (!kqs_pkg::slot_ok(r_free_head)) begin
                        n_status = kqs_pkg::ST_FULL;
                    end else begin
                        val_we      = 1'b1;
                        n_free_head = link_next;
                        tail_we     = 1'b1;
                        n_tail      = r_free_head[kqs_pkg::SLOT_W-1:0];
                        if (!kqs_pkg::slot_ok(head_cur)) begin
                            head_we = 1'b1;
                            n_head  = r_free_head;
                        end else begin
                            link_wr.en   = 1'b1;
                            link_wr.addr = tail_cur;
                            link_wr.data = r_free_head;
                        end
                    end
                end else begin
                    if (!kqs_pkg::slot_ok(head_cur)) begin
                        n_status = kqs_pkg::ST_EMPTY;
                    end else begin
                        // The tail's link is never maintained, so the last entry is found by
                        // comparing against the tail pointer.
                        head_we      = 1'b1;
                        n_head       = (head_cur[kqs_pkg::SLOT_W-1:0] == tail_cur) ?
                                       kqs_pkg::NIL_SLOT : link_next;
                        link_wr.en   = 1'b1;
                        link_wr.addr = head_cur[kqs_pkg::SLOT_W-1:0];
                        link_wr.data = r_free_head;
                        n_free_head  = head_cur;
                        n_read_value = val_q;
                    end
                end
            end
            default: begin
                n_state = kqs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kqs_pkg::S_IDLE;
            r_free_head <= '0;
            r_done      <= 1'b0;
            for (int i = 0; i < kqs_pkg::QUEUE_COUNT; i++) begin
                r_head[i] <= kqs_pkg::NIL_SLOT;
                r_tail[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_done      <= n_done;
            if (head_we) begin
                r_head[r_qnum] <= n_head;
            end
            if (tail_we) begin
                r_tail[r_qnum] <= n_tail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_qnum   <= i_queue_number;
            r_data   <= i_data_value;
        end
        if (n_done) begin
            r_status     <= n_status;
            r_read_value <= n_read_value;
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;

endmodule

`default_nettype wire
